// ===== src/point_transform_perspective_divide_top_macros.svh =====
// Assertion macros shared by the point transform RTL.
`ifndef POINT_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_MACROS_SVH
`define POINT_TRANSFORM_PERSPECTIVE_DIVIDE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked property, quiet while reset is held
`define PTPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked during reset
`define PTPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTPD_ASSERT(lbl, prop, msg)
`define PTPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/ptpd_pkg.sv =====
// Shared constants and types of the point transform block.
package ptpd_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int IO_BITS       = 32;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int NUM_REGS      = 8;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW0_COLS01,
    REG_ROW0_COLS23,
    REG_ROW1_COLS01,
    REG_ROW1_COLS23,
    REG_ROW2_COLS01,
    REG_ROW2_COLS23,
    REG_ROW3_COLS01,
    REG_ROW3_COLS23
  } ptpd_reg_t;

  // reset matrix
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW0_COLS01 = 64'h0000_0001_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW3_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_BITS-1:0] RST_ROW3_COLS23 = 64'h0001_0000_0000_0000;

  // per-row facts that ride beside the divider
  typedef struct packed {
    logic nneg;
    logic nzero;
    logic wzero;
    logic qneg;
  } ptpd_tag_t;
endpackage

// ===== src/ptpd_if.sv =====
// Stream interfaces for the point and result words.
interface ptpd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptpd_pkg::IO_BITS-1:0] in_x;
  logic signed [ptpd_pkg::IO_BITS-1:0] in_y;
  logic signed [ptpd_pkg::IO_BITS-1:0] in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface ptpd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptpd_pkg::IO_BITS-1:0] out_x;
  logic signed [ptpd_pkg::IO_BITS-1:0] out_y;
  logic signed [ptpd_pkg::IO_BITS-1:0] out_z;
  logic                                w_zero;
  logic                                clipped;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output w_zero, output clipped, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input w_zero, input clipped, output ready);
endinterface

// ===== src/point_transform_perspective_divide_top.sv =====
// Top level: 4x4 homogeneous point transform with perspective divide.
// Takes one point word per clock and returns one result word per clock while
// no result waits. Stages: 2 multiply/accumulate, 1 sign and magnitude,
// WORD_BITS+1 divider (a load stage, then one quotient bit each), 1 saturation.
// The three row dividers set the depth. The pipeline holds as a whole while a
// result waits; in_chan.ready is low only then. Matrix registers are written
// through cfg_we/cfg_index/cfg_data while idle, a rule for the user that the
// block does not enforce. When w truncates to zero, outputs saturate by numerator
// sign and w_zero is set; clipped flags any quotient that left the word range.
`include "point_transform_perspective_divide_top_macros.svh"
module point_transform_perspective_divide_top #(
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = ptpd_pkg::WORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ptpd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ptpd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  ptpd_in_if.sink                               in_chan,
  ptpd_out_if.source                            out_chan
);
  localparam int SUM_BITS = 2 * WORD_BITS + 2;
  localparam int DEN_BITS = SUM_BITS - FRAC_BITS;
  localparam int HALF     = ptpd_pkg::CFG_DATA_BITS / 2;
  localparam logic signed [WORD_BITS-1:0] POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] NEG_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] LIM_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] LIM_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic signed [ptpd_pkg::IO_BITS-1:0] POS_MAX_IO = ptpd_pkg::IO_BITS'(POS_MAX);
  localparam logic signed [ptpd_pkg::IO_BITS-1:0] NEG_MIN_IO = ptpd_pkg::IO_BITS'(NEG_MIN);

  logic [ptpd_pkg::CFG_DATA_BITS-1:0] cfg_r [ptpd_pkg::NUM_REGS];
  logic signed [WORD_BITS-1:0]        mtx   [4][4];
  logic signed [WORD_BITS-1:0]        pnt   [3];
  logic                               pipe_en;

  logic                        mac_valid;
  logic signed [SUM_BITS-1:0]  mac_sum [4];

  logic signed [DEN_BITS-1:0]  w_val;
  logic                        w_neg;
  logic [DEN_BITS-1:0]         wmag_nxt;
  logic [SUM_BITS-1:0]         nmask [3];
  logic [SUM_BITS-1:0]         nmag_nxt [3];
  ptpd_pkg::ptpd_tag_t         tag_nxt [3];

  logic                        vp_r;
  logic [DEN_BITS-1:0]         wmag_r;
  logic [SUM_BITS-1:0]         nmag_r [3];
  ptpd_pkg::ptpd_tag_t         tag_r [3];

  logic                        div_valid [3];
  logic [WORD_BITS-1:0]        div_quo   [3];
  logic                        div_ovf   [3];
  ptpd_pkg::ptpd_tag_t         div_tag   [3];

  logic signed [WORD_BITS-1:0] val_nxt  [3];
  logic                        clip_row [3];

  logic                        out_valid_r;
  logic signed [ptpd_pkg::IO_BITS-1:0] out_x_r;
  logic signed [ptpd_pkg::IO_BITS-1:0] out_y_r;
  logic signed [ptpd_pkg::IO_BITS-1:0] out_z_r;
  logic                        w_zero_r;
  logic                        clipped_r;

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= ptpd_pkg::RST_ROW0_COLS01;
      cfg_r[1] <= ptpd_pkg::RST_ROW0_COLS23;
      cfg_r[2] <= ptpd_pkg::RST_ROW1_COLS01;
      cfg_r[3] <= ptpd_pkg::RST_ROW1_COLS23;
      cfg_r[4] <= ptpd_pkg::RST_ROW2_COLS01;
      cfg_r[5] <= ptpd_pkg::RST_ROW2_COLS23;
      cfg_r[6] <= ptpd_pkg::RST_ROW3_COLS01;
      cfg_r[7] <= ptpd_pkg::RST_ROW3_COLS23;
    end else if (cfg_we) begin
      case (ptpd_pkg::ptpd_reg_t'(cfg_index))
        ptpd_pkg::REG_ROW0_COLS01: cfg_r[0] <= cfg_data;
        ptpd_pkg::REG_ROW0_COLS23: cfg_r[1] <= cfg_data;
        ptpd_pkg::REG_ROW1_COLS01: cfg_r[2] <= cfg_data;
        ptpd_pkg::REG_ROW1_COLS23: cfg_r[3] <= cfg_data;
        ptpd_pkg::REG_ROW2_COLS01: cfg_r[4] <= cfg_data;
        ptpd_pkg::REG_ROW2_COLS23: cfg_r[5] <= cfg_data;
        ptpd_pkg::REG_ROW3_COLS01: cfg_r[6] <= cfg_data;
        ptpd_pkg::REG_ROW3_COLS23: cfg_r[7] <= cfg_data;
        default: ;
      endcase
    end
  end

  // matrix entries: low WORD_BITS of each half, two's complement
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mtx[r][c] = cfg_r[r*2 + c/2][(c%2)*HALF +: WORD_BITS];
      end
    end
  end

  assign pnt[0] = in_chan.in_x[WORD_BITS-1:0];
  assign pnt[1] = in_chan.in_y[WORD_BITS-1:0];
  assign pnt[2] = in_chan.in_z[WORD_BITS-1:0];

  // whole pipeline advances unless a result waits
  assign pipe_en       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = pipe_en;

  ptpd_mac #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_chan.valid),
    .pnt       (pnt),
    .mtx       (mtx),
    .out_valid (mac_valid),
    .sum       (mac_sum)
  );

  // truncate w and numerators, split sign and magnitude
  always_comb begin
    w_val    = mac_sum[3][SUM_BITS-1:FRAC_BITS];
    w_neg    = w_val[DEN_BITS-1];
    wmag_nxt = w_neg ? DEN_BITS'(-w_val) : DEN_BITS'(w_val);
    for (int r = 0; r < 3; r++) begin
      nmask[r]          = {mac_sum[r][SUM_BITS-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
      tag_nxt[r].nneg   = mac_sum[r][SUM_BITS-1];
      tag_nxt[r].nzero  = (nmask[r] == '0);
      tag_nxt[r].wzero  = (w_val == '0);
      tag_nxt[r].qneg   = mac_sum[r][SUM_BITS-1] ^ w_neg;
      nmag_nxt[r]       = mac_sum[r][SUM_BITS-1] ? (~nmask[r] + 1'b1) : nmask[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (pipe_en) begin
      vp_r <= mac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      wmag_r <= wmag_nxt;
      nmag_r <= nmag_nxt;
      tag_r  <= tag_nxt;
    end
  end

  // one divider per row
  for (genvar g = 0; g < 3; g++) begin : g_div
    ptpd_div #(
      .WORD_BITS (WORD_BITS),
      .NUM_BITS  (SUM_BITS),
      .DEN_BITS  (DEN_BITS)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (vp_r),
      .num       (nmag_r[g]),
      .den       (wmag_r),
      .tag_in    (tag_r[g]),
      .out_valid (div_valid[g]),
      .quo       (div_quo[g]),
      .ovf       (div_ovf[g]),
      .tag_out   (div_tag[g])
    );
  end

  // sign, saturation and zero-w handling
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_row[r] = 1'b0;
      if (div_tag[r].wzero) begin
        val_nxt[r] = div_tag[r].nzero ? '0 : (div_tag[r].nneg ? NEG_MIN : POS_MAX);
      end else if (div_ovf[r] || div_quo[r] > (div_tag[r].qneg ? LIM_NEG : LIM_POS)) begin
        clip_row[r] = 1'b1;
        val_nxt[r]  = div_tag[r].qneg ? NEG_MIN : POS_MAX;
      end else begin
        val_nxt[r] = div_tag[r].qneg ? -div_quo[r] : div_quo[r];
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= div_valid[0] & div_valid[1] & div_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_x_r   <= ptpd_pkg::IO_BITS'(val_nxt[0]);
      out_y_r   <= ptpd_pkg::IO_BITS'(val_nxt[1]);
      out_z_r   <= ptpd_pkg::IO_BITS'(val_nxt[2]);
      w_zero_r  <= div_tag[0].wzero;
      clipped_r <= clip_row[0] | clip_row[1] | clip_row[2];
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.out_x   = out_x_r;
  assign out_chan.out_y   = out_y_r;
  assign out_chan.out_z   = out_z_r;
  assign out_chan.w_zero  = w_zero_r;
  assign out_chan.clipped = clipped_r;

  `PTPD_ASSERT_ALWAYS(a_wzero_no_clip, out_valid_r |-> !(w_zero_r && clipped_r), "clipped set with zero w")
  `PTPD_ASSERT(a_wzero_sat, out_valid_r && w_zero_r |-> (out_x_r == '0 || out_x_r == POS_MAX_IO || out_x_r == NEG_MIN_IO), "zero w result not saturated")
  `PTPD_ASSERT(a_stall_holds, !pipe_en |=> $stable(vp_r) && $stable(mac_valid) && out_valid_r, "pipeline moved during stall")
endmodule

// ===== src/ptpd_mac.sv =====
// Matrix-vector multiply and row accumulate, two pipeline stages.
module ptpd_mac #(
  parameter int WORD_BITS = ptpd_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF,
  parameter int SUM_BITS  = 2 * ptpd_pkg::WORD_BITS_DEF + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [WORD_BITS-1:0] pnt [3],
  input  logic signed [WORD_BITS-1:0] mtx [4][4],
  output logic                       out_valid,
  output logic signed [SUM_BITS-1:0]  sum [4]
);
  logic signed [2*WORD_BITS-1:0] prod_r  [4][3];
  logic signed [WORD_BITS-1:0]   trans_r [4];
  logic signed [SUM_BITS-1:0]    sum_r   [4];
  logic                          va_r;
  logic                          vb_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // stage A: twelve products, translation column kept aside
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= mtx[r][c] * pnt[c];
        end
        trans_r[r] <= mtx[r][3];
      end
    end
  end

  // stage B: exact row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum_r[r] <= SUM_BITS'(prod_r[r][0]) + SUM_BITS'(prod_r[r][1])
                  + SUM_BITS'(prod_r[r][2])
                  + (SUM_BITS'(trans_r[r]) <<< FRAC_BITS);
      end
    end
  end

  assign out_valid = vb_r;
  assign sum       = sum_r;
endmodule

// ===== src/ptpd_div.sv =====
// Restoring divider, a load stage then one quotient bit per pipeline stage, with overflow detect.
`include "point_transform_perspective_divide_top_macros.svh"
module ptpd_div #(
  parameter int WORD_BITS = ptpd_pkg::WORD_BITS_DEF,
  parameter int NUM_BITS  = 2 * ptpd_pkg::WORD_BITS_DEF + 2,
  parameter int DEN_BITS  = 2 * ptpd_pkg::WORD_BITS_DEF + 2 - ptpd_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [NUM_BITS-1:0]   num,
  input  logic [DEN_BITS-1:0]   den,
  input  ptpd_pkg::ptpd_tag_t   tag_in,
  output logic                  out_valid,
  output logic [WORD_BITS-1:0]  quo,
  output logic                  ovf,
  output ptpd_pkg::ptpd_tag_t   tag_out
);
  localparam int HW = NUM_BITS - WORD_BITS;
  localparam int CW = (HW > DEN_BITS) ? HW : DEN_BITS;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  logic                v_r   [WORD_BITS+1];
  logic [DEN_BITS-1:0] rem_r [WORD_BITS+1];
  logic [DEN_BITS-1:0] den_r [WORD_BITS+1];
  logic [WORD_BITS-1:0] lo_r [WORD_BITS+1];
  logic [WORD_BITS-1:0] q_r  [WORD_BITS+1];
  logic                ovf_r [WORD_BITS+1];
  ptpd_pkg::ptpd_tag_t tag_r [WORD_BITS+1];

  logic [DEN_BITS:0]   step_t   [1:WORD_BITS];
  logic [DEN_BITS:0]   step_d   [1:WORD_BITS];
  logic                step_ge  [1:WORD_BITS];
  logic [DEN_BITS-1:0] rem_nxt  [1:WORD_BITS];

  // upper numerator part against divisor: quotient would not fit
  assign hi_ext  = CW'(num[NUM_BITS-1:WORD_BITS]);
  assign den_ext = CW'(den);

  // one trial subtraction per stage
  always_comb begin
    for (int k = 1; k <= WORD_BITS; k++) begin
      step_t[k]  = {rem_r[k-1], lo_r[k-1][WORD_BITS-1]};
      step_d[k]  = step_t[k] - {1'b0, den_r[k-1]};
      step_ge[k] = step_t[k] >= {1'b0, den_r[k-1]};
      rem_nxt[k] = step_ge[k] ? step_d[k][DEN_BITS-1:0] : step_t[k][DEN_BITS-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= WORD_BITS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= WORD_BITS; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_ext[DEN_BITS-1:0];
      den_r[0] <= den;
      lo_r[0]  <= num[WORD_BITS-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= hi_ext >= den_ext;
      tag_r[0] <= tag_in;
      for (int k = 1; k <= WORD_BITS; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_r[k-1];
        lo_r[k]  <= {lo_r[k-1][WORD_BITS-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][WORD_BITS-2:0], step_ge[k]};
        ovf_r[k] <= ovf_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_valid = v_r[WORD_BITS];
  assign quo       = q_r[WORD_BITS];
  assign ovf       = ovf_r[WORD_BITS];
  assign tag_out   = tag_r[WORD_BITS];

  `PTPD_ASSERT(a_rem_below_den, v_r[WORD_BITS] && !ovf_r[WORD_BITS] && !tag_r[WORD_BITS].wzero |-> rem_r[WORD_BITS] < den_r[WORD_BITS], "divider remainder not below divisor")
endmodule
